// ===== hdl/sem_pkg.sv =====
// shared types, constants and square-root step for the sobel edge magnitude block
`default_nettype none

package sem_pkg;

    localparam int PIX_W  = 8;
    localparam int NUM_CH = 3;
    localparam int CFG_W  = 11;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

    // gradient sums and their squares
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 20;
    localparam int SUM_W  = 21;
    localparam int RAD_W  = 16;

    // above this the rounded root is 256 or more
    localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
    localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

    // digit-by-digit root, two result bits per stage
    localparam int ROOT_W      = 8;
    localparam int REM_W       = 9;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

    // result buffer, power of two
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_pix;   // index 0 blue, 1 green, 2 red

    typedef logic signed [GRAD_W-1:0] t_grad;

    typedef struct packed {
        t_grad [NUM_CH-1:0] gx;
        t_grad [NUM_CH-1:0] gy;
        logic               frame_end;
    } t_grad_word;

    typedef struct packed {
        t_chan [NUM_CH-1:0] mag;
        logic               frame_end;
    } t_mag_word;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_state;

    // one restoring step: bring down two radicand bits, try root*4+1
    function automatic t_sqrt_state sqrt_step(input t_sqrt_state st, input logic [1:0] pair);
        t_sqrt_state      res;
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        acc   = {st.rem, pair};
        trial = {1'b0, st.root, 2'b01};
        if (acc >= trial) begin
            res.rem  = REM_W'(acc - trial);
            res.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = REM_W'(acc);
            res.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sobel_edge_magnitude_top.sv =====
// streaming 3x3 sobel edge magnitude on rgb pixels: line memory, window, result buffer
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  input   | in        | i_valid / o_stall   | i_opcode, i_in_blue, i_in_green, i_in_red
//  output  | out       | o_valid / i_stall   | o_out_blue, o_out_green, o_out_red,
//          |           |                     | o_frame_end
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  one input word per cycle while o_stall is low; a result passes the window, gradient and magnitude registers
//  the line memory is read at accept and written back in the next cycle, so each word
//  uses the single memory port pair once
//  o_stall rises only when 16 results are owed (in flight plus buffered), the buffer depth
//  i_rst_n is synchronous; the line memory is not cleared, rows outside the frame are masked
//  a config write restarts the frame
`default_nettype none

module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [sem_pkg::PIX_W-1:0]     i_in_blue,
    input  logic [sem_pkg::PIX_W-1:0]     i_in_green,
    input  logic [sem_pkg::PIX_W-1:0]     i_in_red,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sem_pkg::PIX_W-1:0]     o_out_blue,
    output logic [sem_pkg::PIX_W-1:0]     o_out_green,
    output logic [sem_pkg::PIX_W-1:0]     o_out_red,
    output logic                          o_frame_end,
    // configuration
    input  logic                          i_cfg_we,
    input  sem_pkg::t_cfg_reg             i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data
);
    import sem_pkg::*;

    // column index, effective width, row index, effective height
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int EWW  = (WW > CFG_W) ? WW : CFG_W;
    localparam int EHW  = (HW > CFG_W) ? HW : CFG_W;
    localparam int CMPW = ((RW > HW) ? RW : HW) + 1;

    // one memory entry: the two rows above the incoming one
    typedef struct packed {
        t_pix top;
        t_pix mid;
    } t_line;

    typedef t_pix [2:0][2:0] t_win;   // [row][col]

    // neighbors that fall outside the frame
    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } t_edge_mask;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [WW-1:0]    w_w;
    logic [HW-1:0]    w_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_RESET;
            r_frame_height <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_w = WW'(1);
        end else if (EWW'(r_frame_width) > EWW'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_h = HW'(1);
        end else if (EHW'(r_frame_height) > EHW'(MAX_HEIGHT)) begin
            w_h = HW'(MAX_HEIGHT);
        end else begin
            w_h = HW'(r_frame_height);
        end
    end

    // ------------------------------------------------------------------
    // accept stage: positions, edge masks, frame end
    // ------------------------------------------------------------------
    logic [CW-1:0]     r_ic;      // input column
    logic [RW-1:0]     r_ir;      // input row, runs past the frame while draining
    logic [CW-1:0]     r_oc;      // output column
    logic [RW-1:0]     r_or;      // output row
    logic [CW-1:0]     n_ic;
    logic [RW-1:0]     n_ir;
    logic [CW-1:0]     n_oc;
    logic [RW-1:0]     n_or;

    logic              w_acc;
    logic              w_take;
    logic              w_in_frame;
    logic              w_col_pos;
    logic              w_emit;
    logic              w_fend;
    logic [CW-1:0]     w_ic;
    logic [RW-1:0]     w_pr;
    t_pix              w_pix;
    t_edge_mask        w_dead;

    logic [FIFO_AW:0]  r_credit;  // results owed: in flight plus buffered
    logic [FIFO_AW:0]  n_credit;
    logic              w_pop;

    assign o_stall = (r_credit == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign w_acc   = i_valid && !o_stall;

    assign w_ic       = (WW'(r_ic) >= w_w) ? '0 : r_ic;
    assign w_in_frame = CMPW'(r_ir) < CMPW'(w_h);
    // a flush inside the frame is dropped; pixels past the frame count as flushes
    assign w_take     = w_acc && !(w_in_frame && (i_opcode == OP_FLUSH));
    assign w_pix      = w_in_frame ? t_pix'({i_in_red, i_in_green, i_in_blue}) : '0;

    // the window centre trails the input by one row and one column
    assign w_col_pos = (w_ic != '0);
    assign w_emit    = (r_ir >= RW'(2)) || ((r_ir == RW'(1)) && w_col_pos);
    assign w_pr      = w_col_pos ? (r_ir - RW'(1)) : (r_ir - RW'(2));

    always_comb begin
        w_dead.row_top   = (w_pr == '0);
        w_dead.row_bot   = (CMPW'(w_pr) + CMPW'(1)) >= CMPW'(w_h);
        w_dead.col_left  = w_col_pos ? (w_ic == CW'(1)) : (w_w == WW'(1));
        w_dead.col_right = !w_col_pos;
    end

    assign w_fend = w_emit && (WW'(r_oc) + WW'(1) == w_w)
                  && (CMPW'(r_or) + CMPW'(1) == CMPW'(w_h));

    always_comb begin
        n_ic = r_ic;
        n_ir = r_ir;
        n_oc = r_oc;
        n_or = r_or;
        if (i_cfg_we) begin
            n_ic = '0;
            n_ir = '0;
            n_oc = '0;
            n_or = '0;
        end else if (w_take) begin
            if (WW'(w_ic) + WW'(1) == w_w) begin
                n_ic = '0;
                n_ir = r_ir + RW'(1);
            end else begin
                n_ic = w_ic + CW'(1);
            end
            if (w_emit) begin
                if (WW'(r_oc) + WW'(1) == w_w) begin
                    n_oc = '0;
                    n_or = r_or + RW'(1);
                end else begin
                    n_oc = r_oc + CW'(1);
                end
            end
            // last output of the frame: next word is pixel 0 of a new frame
            if (w_fend) begin
                n_ic = '0;
                n_ir = '0;
                n_oc = '0;
                n_or = '0;
            end
        end
    end

    assign n_credit = r_credit + {FIFO_AW'(0), (w_take && w_emit)} - {FIFO_AW'(0), w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic     <= '0;
            r_ir     <= '0;
            r_oc     <= '0;
            r_or     <= '0;
            r_credit <= '0;
        end else begin
            r_ic     <= n_ic;
            r_ir     <= n_ir;
            r_oc     <= n_oc;
            r_or     <= n_or;
            r_credit <= n_credit;
        end
    end

    // ------------------------------------------------------------------
    // line memory: read at accept, write back in the next cycle
    // ------------------------------------------------------------------
    t_line            r_line_mem [MAX_WIDTH];
    t_line            r_mem_q;

    logic             r_s1_vld;
    logic             r_s1_emit;
    logic             r_s1_fend;
    logic [CW-1:0]    r_s1_addr;
    t_pix             r_s1_pix;
    t_edge_mask       r_s1_dead;

    // last write, forwarded when the next word reads the same entry (one-column frames)
    logic             r_lw_vld;
    logic [CW-1:0]    r_lw_addr;
    t_line            r_lw_data;

    t_line            w_line;
    t_line            w_wr_line;

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_line_mem[w_ic];
        if (r_s1_vld) begin
            r_line_mem[r_s1_addr] <= w_wr_line;
        end
    end

    assign w_line = (r_lw_vld && (r_lw_addr == r_s1_addr)) ? r_lw_data : r_mem_q;

    always_comb begin
        w_wr_line.top = w_line.mid;
        w_wr_line.mid = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_take;
            r_lw_vld <= r_lw_vld || r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_emit <= w_emit;
            r_s1_fend <= w_fend;
            r_s1_addr <= w_ic;
            r_s1_pix  <= w_pix;
            r_s1_dead <= w_dead;
        end
        if (r_s1_vld) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= w_wr_line;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window: shift in the new column, snapshot with edges masked
    // ------------------------------------------------------------------
    t_win             r_win;
    t_win             w_win_sh;
    t_win             w_win_msk;
    logic             r_s2_vld;
    logic             r_s2_fend;
    t_win             r_s2_win;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_win_sh[r][0] = r_win[r][1];
            w_win_sh[r][1] = r_win[r][2];
        end
        w_win_sh[0][2] = w_line.top;
        w_win_sh[1][2] = w_line.mid;
        w_win_sh[2][2] = r_s1_pix;
    end

    always_comb begin
        logic dead;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                dead = ((r == 0) && r_s1_dead.row_top)  || ((r == 2) && r_s1_dead.row_bot)
                    || ((c == 0) && r_s1_dead.col_left) || ((c == 2) && r_s1_dead.col_right);
                w_win_msk[r][c] = dead ? '0 : w_win_sh[r][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= '0;
            end else if (r_s1_vld) begin
                r_win <= r_s1_fend ? '0 : w_win_sh;
            end
            r_s2_vld <= r_s1_vld && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_fend <= r_s1_fend;
        r_s2_win  <= w_win_msk;
    end

    // ------------------------------------------------------------------
    // gradients: gx right column minus left, gy bottom row minus top
    // ------------------------------------------------------------------
    logic             r_grad_vld;
    t_grad_word       r_grad;
    t_grad_word       n_grad;

    always_comb begin
        logic [GRAD_W-1:0] lft;
        logic [GRAD_W-1:0] rgt;
        logic [GRAD_W-1:0] upr;
        logic [GRAD_W-1:0] lwr;
        n_grad.frame_end = r_s2_fend;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lft = GRAD_W'(r_s2_win[0][0][ch]) + (GRAD_W'(r_s2_win[1][0][ch]) << 1)
                + GRAD_W'(r_s2_win[2][0][ch]);
            rgt = GRAD_W'(r_s2_win[0][2][ch]) + (GRAD_W'(r_s2_win[1][2][ch]) << 1)
                + GRAD_W'(r_s2_win[2][2][ch]);
            upr = GRAD_W'(r_s2_win[0][0][ch]) + (GRAD_W'(r_s2_win[0][1][ch]) << 1)
                + GRAD_W'(r_s2_win[0][2][ch]);
            lwr = GRAD_W'(r_s2_win[2][0][ch]) + (GRAD_W'(r_s2_win[2][1][ch]) << 1)
                + GRAD_W'(r_s2_win[2][2][ch]);
            n_grad.gx[ch] = $signed(rgt - lft);
            n_grad.gy[ch] = $signed(lwr - upr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_vld <= 1'b0;
        end else begin
            r_grad_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grad <= n_grad;
    end

    // ------------------------------------------------------------------
    // magnitude pipeline
    // ------------------------------------------------------------------
    logic             w_mag_vld;
    t_mag_word        w_mag;

    sem_grad_mag u_grad_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_grad_vld),
        .i_grad  (r_grad),
        .o_vld   (w_mag_vld),
        .o_mag   (w_mag)
    );

    // ------------------------------------------------------------------
    // result buffer; credits keep it from overflowing
    // ------------------------------------------------------------------
    t_mag_word           r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_fill;
    t_mag_word           w_head;

    assign o_valid = (r_fill != '0);
    assign w_pop   = o_valid && !i_stall;
    assign w_head  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_mag_vld) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill <= r_fill + {FIFO_AW'(0), w_mag_vld} - {FIFO_AW'(0), w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mag_vld) begin
            r_fifo[r_wr_ptr] <= w_mag;
        end
    end

    assign o_out_blue  = w_head.mag[0];
    assign o_out_green = w_head.mag[1];
    assign o_out_red   = w_head.mag[2];
    assign o_frame_end = w_head.frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // buffered results never outnumber the credits taken for them
    a_fill_le_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_credit)
        else $error("result buffer holds more words than credits");

    a_credit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("credit count above buffer depth");

    // the frame's last output restarts all positions
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_fend) |=> (r_ic == '0 && r_ir == '0 && r_oc == '0 && r_or == '0))
        else $error("positions not cleared after frame end");

    // and the window is empty for the first word of the next frame
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_fend) |=> (r_win == '0))
        else $error("window not cleared after frame end");

endmodule

`default_nettype wire

// ===== hdl/sem_grad_mag.sv =====
// gradient to rounded, clamped magnitude pipeline: squares, sum, root, rounding
`default_nettype none

module sem_grad_mag (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  sem_pkg::t_grad_word i_grad,
    output logic                o_vld,
    output sem_pkg::t_mag_word  o_mag
);
    import sem_pkg::*;

    // squares
    logic                  r_a_vld;
    logic                  r_a_fend;
    logic [SQ_W-1:0]       r_a_sqx [NUM_CH];
    logic [SQ_W-1:0]       r_a_sqy [NUM_CH];
    logic [SQ_W-1:0]       n_a_sqx [NUM_CH];
    logic [SQ_W-1:0]       n_a_sqy [NUM_CH];

    // root stages, index 0 holds the sum
    logic                  r_q_vld  [SQRT_STAGES+1];
    logic                  r_q_fend [SQRT_STAGES+1];
    logic                  r_q_sat  [SQRT_STAGES+1][NUM_CH];
    t_sqrt_state           r_q_st   [SQRT_STAGES+1][NUM_CH];
    logic [RAD_W-1:0]      r_q_rad  [SQRT_STAGES][NUM_CH];
    logic [SUM_W-1:0]      n_sum    [NUM_CH];
    t_sqrt_state           n_q_st   [SQRT_STAGES][NUM_CH];

    // output
    logic                  r_o_vld;
    t_mag_word             r_o_mag;
    t_mag_word             n_o_mag;

    always_comb begin
        logic signed [2*GRAD_W-1:0] px;
        logic signed [2*GRAD_W-1:0] py;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            px = $signed(i_grad.gx[ch]) * $signed(i_grad.gx[ch]);
            py = $signed(i_grad.gy[ch]) * $signed(i_grad.gy[ch]);
            n_a_sqx[ch] = SQ_W'(px);
            n_a_sqy[ch] = SQ_W'(py);
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = SUM_W'(r_a_sqx[ch]) + SUM_W'(r_a_sqy[ch]);
        end
    end

    always_comb begin
        t_sqrt_state      st;
        logic [RAD_W-1:0] rad;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                st  = r_q_st[k][ch];
                rad = r_q_rad[k][ch];
                for (int j = 0; j < SQRT_STEPS; j++) begin
                    st = sqrt_step(st, 2'(rad >> (2 * (ROOT_W - 1 - k * SQRT_STEPS - j))));
                end
                n_q_st[k][ch] = st;
            end
        end
    end

    // round to nearest: up when the remainder exceeds the root
    always_comb begin
        t_sqrt_state fin;
        n_o_mag.frame_end = r_q_fend[SQRT_STAGES];
        for (int ch = 0; ch < NUM_CH; ch++) begin
            fin = r_q_st[SQRT_STAGES][ch];
            if (r_q_sat[SQRT_STAGES][ch]) begin
                n_o_mag.mag[ch] = MAG_MAX;
            end else begin
                n_o_mag.mag[ch] = fin.root + ROOT_W'(fin.rem > REM_W'(fin.root));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k <= SQRT_STAGES; k++) begin
                r_q_vld[k] <= 1'b0;
            end
        end else begin
            r_a_vld    <= i_vld;
            r_q_vld[0] <= r_a_vld;
            for (int k = 1; k <= SQRT_STAGES; k++) begin
                r_q_vld[k] <= r_q_vld[k-1];
            end
            r_o_vld <= r_q_vld[SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_fend <= i_grad.frame_end;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            r_a_sqx[ch] <= n_a_sqx[ch];
            r_a_sqy[ch] <= n_a_sqy[ch];
        end

        r_q_fend[0] <= r_a_fend;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            r_q_sat[0][ch] <= n_sum[ch] > SAT_LIMIT;
            r_q_st[0][ch]  <= '0;
            r_q_rad[0][ch] <= RAD_W'(n_sum[ch]);
        end

        for (int k = 1; k <= SQRT_STAGES; k++) begin
            r_q_fend[k] <= r_q_fend[k-1];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_q_sat[k][ch] <= r_q_sat[k-1][ch];
                r_q_st[k][ch]  <= n_q_st[k-1][ch];
            end
        end
        for (int k = 1; k < SQRT_STAGES; k++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_q_rad[k][ch] <= r_q_rad[k-1][ch];
            end
        end

        r_o_mag <= n_o_mag;
    end

    assign o_vld = r_o_vld;
    assign o_mag = r_o_mag;

endmodule

`default_nettype wire
